// ===== rtl/core/feature_scaling_normalizer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the feature scaling normaliser checks
// Clocked implication forms with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef FEATURE_SCALING_NORMALIZER_CORE_ASSERT_SVH
`define FEATURE_SCALING_NORMALIZER_CORE_ASSERT_SVH

// same-cycle implication
`define FSN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsn check failed");

// next-cycle implication
`define FSN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsn check failed");

`endif

// ===== rtl/core/fsn_pkg.sv =====
// ----------------------------------------------------------------------------
// fsn_pkg
// Shared types, constants and helpers of the feature scaling normaliser.
// ----------------------------------------------------------------------------
package fsn_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int RESULT_W         = 32;
    localparam int MODE_W           = 2;
    localparam int DEF_MAX_ELEMENTS = 64;
    // fixed-point shift of the squared ratio in the standard score path
    localparam int Z_SHIFT          = 34;
    localparam int WIDE_W           = 35;

    localparam logic [MODE_W-1:0] MODE_MINMAX = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZSCORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROBUST = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       last_sample;
    } fsn_in_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] scaled_value;
        logic                       last_result;
        logic                       truncated;
    } fsn_out_t;

    typedef struct packed {
        logic ins;
        logic drain;
    } fsn_cell_ctrl_t;

    function automatic logic signed [RESULT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32'sh7FFF_FFFF);
        lo = -WIDE_W'(33'sh0_8000_0000);
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return v[RESULT_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/fsn_cell.sv =====
// ----------------------------------------------------------------------------
// fsn_cell
// One slot of the sorted row: insertion by neighbour compare, drain to left.
// ----------------------------------------------------------------------------
module fsn_cell import fsn_pkg::*;
(
    input  logic                       clk,
    input  fsn_cell_ctrl_t             ctrl,
    input  logic                       valid,
    input  logic signed [SAMPLE_W-1:0] x,
    input  logic                       left_gt,
    input  logic signed [SAMPLE_W-1:0] left_val,
    input  logic signed [SAMPLE_W-1:0] right_val,
    output logic signed [SAMPLE_W-1:0] val,
    output logic                       gt
);

    logic signed [SAMPLE_W-1:0] val_reg;

    assign gt  = valid && (val_reg > x);
    assign val = val_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            // larger entries move one place right, the new one lands at the boundary
            if (left_gt)
            begin
                val_reg <= left_val;
            end
            else if (gt || !valid)
            begin
                val_reg <= x;
            end
        end
        else if (ctrl.drain)
        begin
            val_reg <= right_val;
        end
    end

endmodule

// ===== rtl/core/fsn_div.sv =====
// ----------------------------------------------------------------------------
// fsn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsn_div import fsn_pkg::*;
#(
    parameter int NW = 87,
    parameter int DW = 53
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNTW = $clog2(NW);

    logic [DW-1:0]   rem_reg,  rem_next;
    logic [NW-1:0]   quo_reg,  quo_next;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [DW:0]     trial;
    logic            ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        quo_next = {quo_reg[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(NW - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== rtl/core/fsn_sqrt.sv =====
// ----------------------------------------------------------------------------
// fsn_sqrt
// Integer square root (floor), one result bit per cycle.
// ----------------------------------------------------------------------------
module fsn_sqrt import fsn_pkg::*;
#(
    parameter int IW = 41
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [IW-1:0]         value,
    output logic                  done,
    output logic [(IW+1)/2-1:0]   root
);

    localparam int RW = (IW + 1) / 2;

    logic [IW-1:0]   val_reg;
    logic [RW-1:0]   s_reg;
    logic [RW-1:0]   mask_reg;
    logic            run_reg;
    logic            done_reg;
    logic [RW-1:0]   cand;
    logic [2*RW-1:0] cand_sq;

    always_comb
    begin
        cand    = s_reg | mask_reg;
        cand_sq = (2*RW)'(cand) * (2*RW)'(cand);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && mask_reg[0])
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            s_reg    <= '0;
            mask_reg <= {1'b1, {(RW-1){1'b0}}};
        end
        else if (run_reg)
        begin
            if (cand_sq <= (2*RW)'(val_reg))
            begin
                s_reg <= cand;
            end
            mask_reg <= mask_reg >> 1;
        end
    end

    assign done = done_reg;
    assign root = s_reg;

endmodule

// ===== rtl/core/feature_scaling_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// feature_scaling_normalizer_core
// Min-max, standard score and median/IQR scaling of a loaded sample set.
// ----------------------------------------------------------------------------
// Samples load at one per cycle while busy is low; each one taken while there
// is room is stored in load order and inserted into a row of sorting cells in
// the same cycle. The item marked last raises busy. The row then drains to
// pick out the median and quartiles; standard score mode adds a sum-of-squares
// pass. Unless the span, IQR or sum of squares is zero, each result takes a
// serial divide of one quotient bit per cycle, and standard score adds a
// square root of one bit per cycle. Every result shows for one cycle on
// result_strobe and must be taken then; busy falls after the last.
// ----------------------------------------------------------------------------
module feature_scaling_normalizer_core import fsn_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fsn_in_t           sample,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata,
    output logic              result_strobe,
    output fsn_out_t          result
);

    localparam int CW   = $clog2(MAX_ELEMENTS + 1);
    localparam int AW   = $clog2(MAX_ELEMENTS);
    localparam int SW   = SAMPLE_W + CW;
    localparam int DLW  = SAMPLE_W + CW + 1;
    localparam int SQW  = 2 * (SAMPLE_W + CW);
    localparam int QW   = SQW + CW;
    localparam int NW   = QW + Z_SHIFT;
    localparam int TW   = Z_SHIFT + CW;
    localparam int RW   = (TW + 1) / 2;

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_DRAIN  = 4'd1;
    localparam logic [3:0] ST_Q_RD   = 4'd2;
    localparam logic [3:0] ST_Q_MUL  = 4'd3;
    localparam logic [3:0] ST_Q_SQ   = 4'd4;
    localparam logic [3:0] ST_Q_ACC  = 4'd5;
    localparam logic [3:0] ST_E_RD   = 4'd6;
    localparam logic [3:0] ST_E_PREP = 4'd7;
    localparam logic [3:0] ST_E_SQ   = 4'd8;
    localparam logic [3:0] ST_E_ZMUL = 4'd9;
    localparam logic [3:0] ST_E_DIV  = 4'd10;
    localparam logic [3:0] ST_E_SQRT = 4'd11;
    localparam logic [3:0] ST_E_OUT  = 4'd12;

    logic [3:0]                 state_reg;
    logic [MODE_W-1:0]          mode_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              k_reg;
    logic [CW-1:0]              i_reg;
    logic signed [SAMPLE_W-1:0] min_reg, max_reg;
    logic signed [SW-1:0]       sum_reg;
    logic                       ovf_reg;
    logic signed [SAMPLE_W-1:0] med_reg, q1_reg, q3_reg;
    logic [QW-1:0]              qsum_reg;
    logic signed [DLW-1:0]      d_reg;
    logic [SQW-1:0]             sq_reg;
    logic                       neg_reg;
    logic signed [RESULT_W-1:0] v_reg;

    logic signed [SAMPLE_W-1:0] mem [MAX_ELEMENTS];
    logic signed [SAMPLE_W-1:0] mem_q;

    logic                       accept, room, store;
    logic                       is_z, is_rob;
    fsn_cell_ctrl_t             cell_ctrl;
    logic signed [SAMPLE_W-1:0] cell_val [MAX_ELEMENTS];
    logic                       cell_gt  [MAX_ELEMENTS];

    logic [CW+1:0]              idx3;
    logic signed [DLW-1:0]      nx;
    logic signed [2*DLW-1:0]    d_sq;
    logic signed [SAMPLE_W:0]   span, iqr, diff_rob, diff_mm, diff_sel, mag;
    logic                       span_nz, iqr_nz;
    logic [SAMPLE_W:0]          den_base;
    logic                       i_last;

    logic                       div_start, div_done;
    logic [NW-1:0]              div_num, div_quot;
    logic [QW-1:0]              div_den;
    logic [QW-1:0]              zprod;
    logic                       sqrt_start, sqrt_done;
    logic [RW-1:0]              sqrt_root;
    logic [RW:0]                r_round;
    logic signed [WIDE_W-1:0]   q_wide, r_wide, rob_wide;

    assign accept = start && !busy;
    assign room   = count_reg < CW'(MAX_ELEMENTS);
    assign store  = accept && room;
    assign is_z   = mode_reg == MODE_ZSCORE;
    assign is_rob = mode_reg == MODE_ROBUST;

    assign cell_ctrl.ins   = store;
    assign cell_ctrl.drain = state_reg == ST_DRAIN;

    genvar g;
    generate
        for (g = 0; g < MAX_ELEMENTS; g++)
        begin : g_cell
            fsn_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .valid     (CW'(g) < count_reg),
                .x         (sample.sample_value),
                .left_gt   ((g == 0) ? 1'b0 : cell_gt[(g == 0) ? 0 : g - 1]),
                .left_val  (cell_val[(g == 0) ? 0 : g - 1]),
                .right_val (cell_val[(g == MAX_ELEMENTS - 1) ? g : g + 1]),
                .val       (cell_val[g]),
                .gt        (cell_gt[g])
            );
        end
    endgenerate

    // sample store, load order
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[count_reg[AW-1:0]] <= sample.sample_value;
        end
        mem_q <= mem[i_reg[AW-1:0]];
    end

    always_comb
    begin
        idx3     = (CW+2)'(count_reg) + {count_reg, 1'b0};
        nx       = $signed({1'b0, count_reg}) * mem_q;
        d_sq     = d_reg * d_reg;
        span     = (SAMPLE_W+1)'(max_reg) - (SAMPLE_W+1)'(min_reg);
        iqr      = (SAMPLE_W+1)'(q3_reg) - (SAMPLE_W+1)'(q1_reg);
        span_nz  = span != '0;
        iqr_nz   = iqr != '0;
        diff_rob = (SAMPLE_W+1)'(mem_q) - (SAMPLE_W+1)'(med_reg);
        diff_mm  = (SAMPLE_W+1)'(mem_q) - (SAMPLE_W+1)'(min_reg);
        diff_sel = is_rob ? diff_rob : diff_mm;
        mag      = diff_sel[SAMPLE_W] ? -diff_sel : diff_sel;
        den_base = is_rob ? iqr : span;
        i_last   = i_reg == (count_reg - 1'b1);
        zprod    = QW'(sq_reg) * QW'(count_reg);
        r_round  = ({1'b0, sqrt_root} + 1'b1) >> 1;
        q_wide   = WIDE_W'({1'b0, div_quot[RESULT_W:0]});
        r_wide   = WIDE_W'(r_round);
        rob_wide = WIDE_W'($signed({diff_rob, 16'd0}));
    end

    assign div_start = (state_reg == ST_E_ZMUL) ||
                       (state_reg == ST_E_PREP && !is_z && (is_rob ? iqr_nz : span_nz));
    assign div_num   = (state_reg == ST_E_ZMUL) ? {zprod, Z_SHIFT'(0)}
                     : NW'({mag, 17'd0}) + NW'(den_base);
    assign div_den   = (state_reg == ST_E_ZMUL) ? qsum_reg : QW'({den_base, 1'b0});
    assign sqrt_start = (state_reg == ST_E_DIV) && div_done && is_z;

    fsn_div #(.NW(NW), .DW(QW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    fsn_sqrt #(.IW(TW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (div_quot[TW-1:0]),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            mode_reg  <= MODE_MINMAX;
            count_reg <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            min_reg   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            max_reg   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + 1'b1;
                            sum_reg   <= sum_reg + SW'(sample.sample_value);
                            if (sample.sample_value < min_reg)
                            begin
                                min_reg <= sample.sample_value;
                            end
                            if (sample.sample_value > max_reg)
                            begin
                                max_reg <= sample.sample_value;
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (sample.last_sample)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    // cell 0 holds the k-th smallest entry
                    if (k_reg == (count_reg >> 2))
                    begin
                        q1_reg <= cell_val[0];
                    end
                    if (k_reg == (count_reg >> 1))
                    begin
                        med_reg <= cell_val[0];
                    end
                    if ((CW+2)'(k_reg) == (idx3 >> 2))
                    begin
                        q3_reg <= cell_val[0];
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == count_reg - 1'b1)
                    begin
                        i_reg     <= '0;
                        qsum_reg  <= '0;
                        state_reg <= is_z ? ST_Q_RD : ST_E_RD;
                    end
                end
                ST_Q_RD:
                begin
                    state_reg <= ST_Q_MUL;
                end
                ST_Q_MUL:
                begin
                    d_reg     <= nx - DLW'(sum_reg);
                    state_reg <= ST_Q_SQ;
                end
                ST_Q_SQ:
                begin
                    sq_reg    <= d_sq[SQW-1:0];
                    state_reg <= ST_Q_ACC;
                end
                ST_Q_ACC:
                begin
                    qsum_reg <= qsum_reg + QW'(sq_reg);
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_E_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_Q_RD;
                    end
                end
                ST_E_RD:
                begin
                    state_reg <= ST_E_PREP;
                end
                ST_E_PREP:
                begin
                    neg_reg <= is_rob && diff_rob[SAMPLE_W];
                    if (is_z)
                    begin
                        d_reg     <= nx - DLW'(sum_reg);
                        state_reg <= ST_E_SQ;
                    end
                    else if (is_rob)
                    begin
                        if (iqr_nz)
                        begin
                            state_reg <= ST_E_DIV;
                        end
                        else
                        begin
                            v_reg     <= sat32(rob_wide);
                            state_reg <= ST_E_OUT;
                        end
                    end
                    else if (span_nz)
                    begin
                        state_reg <= ST_E_DIV;
                    end
                    else
                    begin
                        v_reg     <= '0;
                        state_reg <= ST_E_OUT;
                    end
                end
                ST_E_SQ:
                begin
                    if (qsum_reg == '0)
                    begin
                        v_reg     <= '0;
                        state_reg <= ST_E_OUT;
                    end
                    else
                    begin
                        sq_reg    <= d_sq[SQW-1:0];
                        neg_reg   <= d_reg[DLW-1];
                        state_reg <= ST_E_ZMUL;
                    end
                end
                ST_E_ZMUL:
                begin
                    state_reg <= ST_E_DIV;
                end
                ST_E_DIV:
                begin
                    if (div_done)
                    begin
                        if (is_z)
                        begin
                            state_reg <= ST_E_SQRT;
                        end
                        else
                        begin
                            v_reg     <= sat32(neg_reg ? -q_wide : q_wide);
                            state_reg <= ST_E_OUT;
                        end
                    end
                end
                ST_E_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        v_reg     <= sat32(neg_reg ? -r_wide : r_wide);
                        state_reg <= ST_E_OUT;
                    end
                end
                ST_E_OUT:
                begin
                    if (i_last)
                    begin
                        // drop the set, ready for the next load
                        count_reg <= '0;
                        min_reg   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                        max_reg   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                        sum_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_E_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy                = state_reg != ST_LOAD;
    assign result_strobe       = state_reg == ST_E_OUT;
    assign result.scaled_value = v_reg;
    assign result.last_result  = i_last;
    assign result.truncated    = ovf_reg;

endmodule

// ===== rtl/core/fsn_checker.sv =====
// ----------------------------------------------------------------------------
// fsn_assert_checker
// Port-level transaction checks of the feature scaling normaliser.
// ----------------------------------------------------------------------------
`include "feature_scaling_normalizer_core_assert.svh"

module fsn_assert_checker import fsn_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input fsn_in_t  sample,
    input logic     result_strobe,
    input fsn_out_t result
);

    // results only while a set is being worked off
    `FSN_ASSERT_IMP(a_strobe_busy, clk, rst_n, result_strobe, busy)
    // a non-final sample keeps the block loading
    `FSN_ASSERT_NXT(a_load_idle, clk, rst_n, start && !busy && !sample.last_sample, !busy)
    // the final sample starts the output phase
    `FSN_ASSERT_NXT(a_last_busy, clk, rst_n, start && !busy && sample.last_sample, busy)
    // the final result frees the block
    `FSN_ASSERT_NXT(a_end_idle, clk, rst_n, result_strobe && result.last_result, !busy)
    // results never come in consecutive cycles
    `FSN_ASSERT_NXT(a_strobe_gap, clk, rst_n, result_strobe, !result_strobe)

endmodule

bind feature_scaling_normalizer_core fsn_assert_checker u_fsn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .sample        (sample),
    .result_strobe (result_strobe),
    .result        (result)
);
